/* design/mgpc_pkg.sv */
package mgpc_pkg;

    localparam int ANGLE_BITS    = 18;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int ATAN_SHIFT    = 32 - ANGLE_BITS;
    localparam int HALF          = 2 ** (ANGLE_BITS - 1);
    localparam int QUARTER       = 2 ** (ANGLE_BITS - 2);

    // Field and datapath widths.
    localparam int POS_W   = 16;
    localparam int HEAD_W  = 17;
    localparam int DIFF_W  = 17;
    localparam int DIST_W  = 17;
    localparam int ERR_W   = 18;
    localparam int LIM_W   = 10;
    localparam int ATOL_W  = 16;
    localparam int TURN_W  = 11;
    localparam int WHEEL_W = 16;

    localparam int VEC_SHIFT = 20;
    localparam int VEC_W     = DIFF_W + VEC_SHIFT + 3;
    localparam int Q_SHIFT   = 30;
    localparam int KINV_W    = 30;
    localparam logic [KINV_W-1:0] KINV_Q30 = KINV_W'(652032874);
    localparam int ROT_W     = 44;
    localparam int ROT_ZW    = ANGLE_BITS + 1;
    localparam int SUM_W     = 46;

    // Yaw to angle units: yaw * 2^ANGLE_BITS / 36000 = yaw * 2^(ANGLE_BITS-5) / 1125.
    // The yaw is split as 1125 * a + b, and each part is divided by a reciprocal multiply.
    localparam int YAW_DIV   = 1125;
    localparam int YAW_OFS_Q = 59;
    localparam int YAW_OFS   = YAW_OFS_Q * YAW_DIV;
    localparam int YAW_RND   = 36000 / 64;
    localparam int YSH       = ANGLE_BITS - 5;
    localparam int YU_W      = 18;
    localparam int R1_SHIFT  = YU_W + 11;
    localparam int R1_W      = YU_W + 1;
    localparam int R1        = (2 ** R1_SHIFT + YAW_DIV - 1) / YAW_DIV;
    localparam logic [R1_W-1:0] R1_C = R1_W'(R1);
    localparam int P1_W      = YU_W + R1_W;
    localparam int Q1_W      = P1_W - R1_SHIFT;
    localparam int A_W       = Q1_W + 1;
    localparam int B_W       = 11;
    localparam int V2_W      = ANGLE_BITS + 6;
    localparam int R2_SHIFT  = V2_W + 11;
    localparam int R2_W      = V2_W + 1;
    localparam longint R2    = ((longint'(1) << R2_SHIFT) + YAW_DIV - 1) / YAW_DIV;
    localparam logic [R2_W-1:0] R2_C = R2_W'(R2);
    localparam int P2_W      = V2_W + R2_W;
    localparam int Q2_W      = P2_W - R2_SHIFT;

    // Turn term: |err| / 10 by reciprocal multiply.
    localparam int TURN_DIV  = 10;
    localparam int TR_SHIFT  = ERR_W + 4;
    localparam int TR_W      = ERR_W + 1;
    localparam int TR        = (2 ** TR_SHIFT + TURN_DIV - 1) / TURN_DIV;
    localparam logic [TR_W-1:0] TR_C = TR_W'(TR);
    localparam int PT_W      = ERR_W + TR_W;
    localparam int QT_W      = PT_W - TR_SHIFT;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL   = CFG_IDX_W'(3);
    localparam logic [LIM_W-1:0]  RST_SPEED_LIMIT = LIM_W'(500);
    localparam logic [LIM_W-1:0]  RST_TURN_LIMIT  = LIM_W'(200);
    localparam logic [LIM_W-1:0]  RST_DIST_TOL    = LIM_W'(5);
    localparam logic [ATOL_W-1:0] RST_ANGLE_TOL   = ATOL_W'(200);

    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Arctangent of 2^-idx in angle units, rounded half up.
    function automatic logic [ANGLE_BITS-1:0] atan_unit(input int idx);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[idx % ATAN_ENTRIES]} + (33'd1 << (ATAN_SHIFT - 1));
        return t[ATAN_SHIFT +: ANGLE_BITS];
    endfunction

    typedef struct packed {
        logic [ANGLE_BITS-1:0]    yaw_a;
        logic [LIM_W-1:0]         speed;
        logic signed [TURN_W-1:0] turn;
        logic                     arrive;
        logic                     zero;
    } t_vec_side;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn;
        logic                     arrive;
        logic                     neg;
    } t_rot_side;

endpackage

/* design/mgpc_vec_cordic.sv */
module mgpc_vec_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [mgpc_pkg::VEC_W-1:0]     i_x,
    input  logic signed [mgpc_pkg::VEC_W-1:0]     i_y,
    input  logic [mgpc_pkg::ANGLE_BITS-1:0]       i_z,
    input  mgpc_pkg::t_vec_side                   i_side,
    output logic                                  o_valid,
    output logic [mgpc_pkg::ANGLE_BITS-1:0]       o_z,
    output mgpc_pkg::t_vec_side                   o_side
);
    import mgpc_pkg::*;

    logic                    r_v    [CORDIC_STAGES];
    logic signed [VEC_W-1:0] r_x    [CORDIC_STAGES];
    logic signed [VEC_W-1:0] r_y    [CORDIC_STAGES];
    logic [ANGLE_BITS-1:0]   r_z    [CORDIC_STAGES];
    t_vec_side               r_side [CORDIC_STAGES];

    logic                    w_v    [CORDIC_STAGES];
    logic signed [VEC_W-1:0] w_x    [CORDIC_STAGES];
    logic signed [VEC_W-1:0] w_y    [CORDIC_STAGES];
    logic [ANGLE_BITS-1:0]   w_z    [CORDIC_STAGES];
    t_vec_side               w_side [CORDIC_STAGES];

    logic signed [VEC_W-1:0] n_x [CORDIC_STAGES];
    logic signed [VEC_W-1:0] n_y [CORDIC_STAGES];
    logic [ANGLE_BITS-1:0]   n_z [CORDIC_STAGES];

    always_comb begin
        w_v[0]    = i_valid;
        w_x[0]    = i_x;
        w_y[0]    = i_y;
        w_z[0]    = i_z;
        w_side[0] = i_side;
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            w_v[k]    = r_v[k-1];
            w_x[k]    = r_x[k-1];
            w_y[k]    = r_y[k-1];
            w_z[k]    = r_z[k-1];
            w_side[k] = r_side[k-1];
        end
    end

    // Each stage drives y toward zero and accumulates the angle turned.
    always_comb begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (!w_y[k][VEC_W-1]) begin
                n_x[k] = w_x[k] + (w_y[k] >>> k);
                n_y[k] = w_y[k] - (w_x[k] >>> k);
                n_z[k] = w_z[k] + atan_unit(k);
            end else begin
                n_x[k] = w_x[k] - (w_y[k] >>> k);
                n_y[k] = w_y[k] + (w_x[k] >>> k);
                n_z[k] = w_z[k] - atan_unit(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STAGES; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < CORDIC_STAGES; k++) r_v[k] <= w_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_z[k]    <= n_z[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_z     = r_z[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

/* design/mgpc_rot_cordic.sv */
module mgpc_rot_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [mgpc_pkg::ROT_W-1:0]     i_x,
    input  logic signed [mgpc_pkg::ROT_ZW-1:0]    i_z,
    input  mgpc_pkg::t_rot_side                   i_side,
    output logic                                  o_valid,
    output logic signed [mgpc_pkg::ROT_W-1:0]     o_x,
    output logic signed [mgpc_pkg::ROT_W-1:0]     o_y,
    output mgpc_pkg::t_rot_side                   o_side
);
    import mgpc_pkg::*;

    logic                     r_v    [CORDIC_STAGES];
    logic signed [ROT_W-1:0]  r_x    [CORDIC_STAGES];
    logic signed [ROT_W-1:0]  r_y    [CORDIC_STAGES];
    logic signed [ROT_ZW-1:0] r_z    [CORDIC_STAGES];
    t_rot_side                r_side [CORDIC_STAGES];

    logic                     w_v    [CORDIC_STAGES];
    logic signed [ROT_W-1:0]  w_x    [CORDIC_STAGES];
    logic signed [ROT_W-1:0]  w_y    [CORDIC_STAGES];
    logic signed [ROT_ZW-1:0] w_z    [CORDIC_STAGES];
    t_rot_side                w_side [CORDIC_STAGES];

    logic signed [ROT_W-1:0]  n_x [CORDIC_STAGES];
    logic signed [ROT_W-1:0]  n_y [CORDIC_STAGES];
    logic signed [ROT_ZW-1:0] n_z [CORDIC_STAGES];

    always_comb begin
        w_v[0]    = i_valid;
        w_x[0]    = i_x;
        w_y[0]    = '0;
        w_z[0]    = i_z;
        w_side[0] = i_side;
        for (int k = 1; k < CORDIC_STAGES; k++) begin
            w_v[k]    = r_v[k-1];
            w_x[k]    = r_x[k-1];
            w_y[k]    = r_y[k-1];
            w_z[k]    = r_z[k-1];
            w_side[k] = r_side[k-1];
        end
    end

    // Each stage rotates the vector to drive the residual angle toward zero.
    always_comb begin
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (!w_z[k][ROT_ZW-1]) begin
                n_x[k] = w_x[k] - (w_y[k] >>> k);
                n_y[k] = w_y[k] + (w_x[k] >>> k);
                n_z[k] = w_z[k] - signed'({1'b0, atan_unit(k)});
            end else begin
                n_x[k] = w_x[k] + (w_y[k] >>> k);
                n_y[k] = w_y[k] - (w_x[k] >>> k);
                n_z[k] = w_z[k] + signed'({1'b0, atan_unit(k)});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STAGES; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < CORDIC_STAGES; k++) r_v[k] <= w_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_z[k]    <= n_z[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_y     = r_y[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

/* design/mecanum_goto_point_controller_top.sv */
// Point-to-point controller for a mecanum base, one control tick per transaction.
// Input channel (i_valid / o_ready): target pose, current position and gyro yaw.
// Output channel (o_valid / i_ready): four wheel commands and the busy flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and data;
// o_cfg_ready is always high. Write registers only while no tick is in flight.
// From input transaction to result valid, a tick passes the two CORDIC pipelines
// of sixteen stages each (one vectoring for the heading of the target, one
// rotating the speed vector) plus the yaw scaling and mixing stages around
// them. One tick is accepted every cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds in place and o_ready drops
// in the same cycle, so nothing is dropped or repeated.
// A synchronous reset empties the pipeline and restores the default limits
// and tolerances.
module mecanum_goto_point_controller_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [mgpc_pkg::POS_W-1:0]      i_target_x,
    input  logic signed [mgpc_pkg::POS_W-1:0]      i_target_y,
    input  logic signed [mgpc_pkg::HEAD_W-1:0]     i_target_heading,
    input  logic signed [mgpc_pkg::POS_W-1:0]      i_current_x,
    input  logic signed [mgpc_pkg::POS_W-1:0]      i_current_y,
    input  logic signed [mgpc_pkg::HEAD_W-1:0]     i_yaw,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [mgpc_pkg::WHEEL_W-1:0]    o_wheel_a,
    output logic signed [mgpc_pkg::WHEEL_W-1:0]    o_wheel_b,
    output logic signed [mgpc_pkg::WHEEL_W-1:0]    o_wheel_c,
    output logic signed [mgpc_pkg::WHEEL_W-1:0]    o_wheel_d,
    output logic                                   o_busy_res,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mgpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mgpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mgpc_pkg::*;

    logic en;

    logic [LIM_W-1:0]  r_speed_limit;
    logic [LIM_W-1:0]  r_turn_limit;
    logic [LIM_W-1:0]  r_dist_tol;
    logic [ATOL_W-1:0] r_angle_tol;

    // Stage 1
    logic                     r1_v;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic signed [ERR_W-1:0]  r1_err;
    logic [YU_W-1:0]          r1_yu;
    // Stage 2
    logic                     r2_v;
    logic signed [DIFF_W-1:0] r2_dx, r2_dy;
    logic [DIST_W-1:0]        r2_dist;
    logic [ERR_W-1:0]         r2_aerr;
    logic                     r2_eneg;
    logic [PT_W-1:0]          r2_pt;
    logic [P1_W-1:0]          r2_p1;
    logic [YU_W-1:0]          r2_yu;
    // Stage 3
    logic                     r3_v;
    logic signed [DIFF_W-1:0] r3_dx, r3_dy;
    logic [LIM_W-1:0]         r3_speed;
    logic                     r3_arrive;
    logic signed [TURN_W-1:0] r3_turn;
    logic [Q1_W-1:0]          r3_q1;
    logic [B_W-1:0]           r3_b;
    // Stage 4
    logic                     r4_v;
    logic signed [DIFF_W-1:0] r4_dx, r4_dy;
    logic [LIM_W-1:0]         r4_speed;
    logic                     r4_arrive;
    logic signed [TURN_W-1:0] r4_turn;
    logic signed [A_W-1:0]    r4_a;
    logic [P2_W-1:0]          r4_p2;
    // Stage 5: vectoring start
    logic                     r5_v;
    logic signed [VEC_W-1:0]  r5_x, r5_y;
    logic [ANGLE_BITS-1:0]    r5_z;
    t_vec_side                r5_side;
    // Stage after vectoring: rotation start
    logic                     r6_v;
    logic signed [ROT_W-1:0]  r6_x;
    logic signed [ROT_ZW-1:0] r6_z;
    t_rot_side                r6_side;
    // Mix stage
    logic                     r7_v;
    logic                     r7_arrive;
    logic signed [SUM_W-1:0]  r7_sa, r7_sb, r7_sc, r7_sd;
    // Output register
    logic                     r_out_valid;
    logic [WHEEL_W-1:0]       r_wa, r_wb, r_wc, r_wd;
    logic                     r_busy;

    logic                     vec_valid;
    logic [ANGLE_BITS-1:0]    vec_z;
    t_vec_side                vec_side;
    logic                     rot_valid;
    logic signed [ROT_W-1:0]  rot_x, rot_y;
    t_rot_side                rot_side;

    logic [DIFF_W-1:0]        abs_dx, abs_dy;
    logic [QT_W-1:0]          turn_q;
    logic [LIM_W-1:0]         turn_mag;
    logic [Q1_W-1:0]          q1;
    logic [V2_W-1:0]          v2;
    logic signed [VEC_W-1:0]  vx0, vy0;
    logic [ANGLE_BITS-1:0]    dir_u;
    logic signed [ROT_ZW-1:0] dir_z;
    logic signed [ROT_W-1:0]  mx, my;
    logic signed [SUM_W-1:0]  sx, sy, stq;

    assign en          = !r_out_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= RST_SPEED_LIMIT;
            r_turn_limit  <= RST_TURN_LIMIT;
            r_dist_tol    <= RST_DIST_TOL;
            r_angle_tol   <= RST_ANGLE_TOL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[LIM_W-1:0];
                CFG_TURN_LIMIT:  r_turn_limit  <= i_cfg_data[LIM_W-1:0];
                CFG_DIST_TOL:    r_dist_tol    <= i_cfg_data[LIM_W-1:0];
                CFG_ANGLE_TOL:   r_angle_tol   <= i_cfg_data[ATOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r7_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_v        <= i_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r6_v        <= vec_valid;
            r7_v        <= rot_valid;
            r_out_valid <= r7_v;
        end
    end

    always_comb begin
        abs_dx   = r1_dx[DIFF_W-1] ? DIFF_W'(-r1_dx) : DIFF_W'(r1_dx);
        abs_dy   = r1_dy[DIFF_W-1] ? DIFF_W'(-r1_dy) : DIFF_W'(r1_dy);
        turn_q   = r2_pt[TR_SHIFT +: QT_W];
        turn_mag = (turn_q > QT_W'(r_turn_limit)) ? r_turn_limit : turn_q[LIM_W-1:0];
        q1       = r2_p1[R1_SHIFT +: Q1_W];
        v2       = (V2_W'(r3_b) << YSH) + V2_W'(YAW_RND);
        vx0      = VEC_W'(r4_dx) <<< VEC_SHIFT;
        vy0      = VEC_W'(r4_dy) <<< VEC_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= DIFF_W'(i_target_x) - DIFF_W'(i_current_x);
            r1_dy  <= DIFF_W'(i_target_y) - DIFF_W'(i_current_y);
            r1_err <= ERR_W'(i_target_heading) - ERR_W'(i_yaw);
            // Offset by a multiple of 1125 so the yaw division sees a positive value.
            r1_yu  <= YU_W'(ERR_W'(i_yaw)) + YU_W'(YAW_OFS);

            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_dist <= DIST_W'(abs_dx) + DIST_W'(abs_dy);
            r2_aerr <= r1_err[ERR_W-1] ? ERR_W'(-r1_err) : ERR_W'(r1_err);
            r2_eneg <= r1_err[ERR_W-1];
            r2_pt   <= PT_W'(r1_err[ERR_W-1] ? ERR_W'(-r1_err) : ERR_W'(r1_err))
                       * PT_W'(TR_C);
            r2_p1   <= P1_W'(r1_yu) * P1_W'(R1_C);
            r2_yu   <= r1_yu;

            r3_dx     <= r2_dx;
            r3_dy     <= r2_dy;
            r3_speed  <= (r2_dist > DIST_W'(r_speed_limit)) ? r_speed_limit
                                                             : r2_dist[LIM_W-1:0];
            r3_arrive <= (r2_dist <= DIST_W'(r_dist_tol))
                         && (r2_aerr <= ERR_W'(r_angle_tol));
            r3_turn   <= r2_eneg ? -signed'(TURN_W'(turn_mag)) : signed'(TURN_W'(turn_mag));
            r3_q1     <= q1;
            r3_b      <= B_W'(r2_yu - YU_W'(q1) * YU_W'(YAW_DIV));

            r4_dx     <= r3_dx;
            r4_dy     <= r3_dy;
            r4_speed  <= r3_speed;
            r4_arrive <= r3_arrive;
            r4_turn   <= r3_turn;
            r4_a      <= signed'({1'b0, r3_q1}) - A_W'(YAW_OFS_Q);
            r4_p2     <= P2_W'(v2) * P2_W'(R2_C);

            // A negative dx is folded into the right half-plane by a half turn.
            r5_x <= r4_dx[DIFF_W-1] ? -vx0 : vx0;
            r5_y <= r4_dx[DIFF_W-1] ? -vy0 : vy0;
            r5_z <= r4_dx[DIFF_W-1] ? ANGLE_BITS'(HALF) : '0;
            r5_side.yaw_a  <= (ANGLE_BITS'(r4_a) << YSH)
                              + ANGLE_BITS'(r4_p2[R2_SHIFT +: Q2_W]);
            r5_side.speed  <= r4_speed;
            r5_side.turn   <= r4_turn;
            r5_side.arrive <= r4_arrive;
            r5_side.zero   <= (r4_dx == '0) && (r4_dy == '0);
        end
    end

    mgpc_vec_cordic u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_x     (r5_x),
        .i_y     (r5_y),
        .i_z     (r5_z),
        .i_side  (r5_side),
        .o_valid (vec_valid),
        .o_z     (vec_z),
        .o_side  (vec_side)
    );

    // Travel direction relative to the robot, wrapped to a signed half turn.
    always_comb begin
        dir_u = (vec_side.zero ? '0 : vec_z) - vec_side.yaw_a;
        dir_z = ROT_ZW'(signed'(dir_u));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_x <= ROT_W'(vec_side.speed) * ROT_W'(KINV_Q30);
            if (dir_z > ROT_ZW'(QUARTER)) begin
                r6_z        <= dir_z - ROT_ZW'(HALF);
                r6_side.neg <= 1'b1;
            end else if (dir_z < -ROT_ZW'(QUARTER)) begin
                r6_z        <= dir_z + ROT_ZW'(HALF);
                r6_side.neg <= 1'b1;
            end else begin
                r6_z        <= dir_z;
                r6_side.neg <= 1'b0;
            end
            r6_side.turn   <= vec_side.turn;
            r6_side.arrive <= vec_side.arrive;
        end
    end

    mgpc_rot_cordic u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_x     (r6_x),
        .i_z     (r6_z),
        .i_side  (r6_side),
        .o_valid (rot_valid),
        .o_x     (rot_x),
        .o_y     (rot_y),
        .o_side  (rot_side)
    );

    always_comb begin
        mx  = rot_side.neg ? -rot_x : rot_x;
        my  = rot_side.neg ? -rot_y : rot_y;
        sx  = SUM_W'(mx);
        sy  = SUM_W'(my);
        stq = SUM_W'(rot_side.turn) <<< Q_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sa     <= sx - sy - stq;
            r7_sb     <= sx + sy + stq;
            r7_sc     <= sx + sy - stq;
            r7_sd     <= sx - sy + stq;
            r7_arrive <= rot_side.arrive;
        end
    end

    // Truncate a Q30 sum toward zero, flip where the wheel is mounted reversed.
    function automatic logic [WHEEL_W-1:0] to_wheel(input logic signed [SUM_W-1:0] s,
                                                    input logic flip);
        logic [WHEEL_W-1:0] q;
        q = s[Q_SHIFT +: WHEEL_W]
            + WHEEL_W'(s[SUM_W-1] && (|s[Q_SHIFT-1:0]));
        return flip ? -q : q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wa   <= r7_arrive ? '0 : to_wheel(r7_sa, 1'b1);
            r_wb   <= r7_arrive ? '0 : to_wheel(r7_sb, 1'b0);
            r_wc   <= r7_arrive ? '0 : to_wheel(r7_sc, 1'b1);
            r_wd   <= r7_arrive ? '0 : to_wheel(r7_sd, 1'b0);
            r_busy <= !r7_arrive;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_wheel_a  = signed'(r_wa);
    assign o_wheel_b  = signed'(r_wb);
    assign o_wheel_c  = signed'(r_wc);
    assign o_wheel_d  = signed'(r_wd);
    assign o_busy_res = r_busy;

    // An arrived result always commands all wheels to stop.
    a_arrive_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |->
            o_wheel_a == '0 && o_wheel_b == '0 && o_wheel_c == '0 && o_wheel_d == '0)
        else $error("arrived result with nonzero wheel command");

    // A stalled result must hold the input side off in the same cycle.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while result stalled");

    // The first cycle out of reset sees an empty pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !o_valid)
        else $error("result valid right after reset");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

class wheel_scoreboard;
    typedef struct packed {
        logic signed [15:0] wa;
        logic signed [15:0] wb;
        logic signed [15:0] wc;
        logic signed [15:0] wd;
        logic               busy;
    } t_wheels;

    t_wheels pending[$];
    int      mismatches;
    int      unexpected;

    logic [9:0]  speed_limit;
    logic [9:0]  turn_limit;
    logic [9:0]  dist_tol;
    logic [15:0] angle_tol;

    function new();
        mismatches = 0;
        unexpected = 0;
        speed_limit = 10'd500;
        turn_limit = 10'd200;
        dist_tol = 10'd5;
        angle_tol = 16'd200;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
        case (idx)
            mgpc_pkg::CFG_SPEED_LIMIT: speed_limit = data[9:0];
            mgpc_pkg::CFG_TURN_LIMIT:  turn_limit = data[9:0];
            mgpc_pkg::CFG_DIST_TOL:    dist_tol = data[9:0];
            mgpc_pkg::CFG_ANGLE_TOL:   angle_tol = data;
            default: ;
        endcase
    endfunction

    // Arctangent of 2^-i in 2^-18 turn units, rounded half up.
    function longint atan_step(int i);
        longint t;
        t = longint'(mgpc_pkg::ATAN_TURN32[i]);
        return (t + (longint'(1) << 13)) >>> 14;
    endfunction

    function longint heading_of(longint dx, longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx <<< 20;
        y = dy <<< 20;
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = longint'(1) << 17;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function logic [15:0] to_wheel(longint q30, bit flip);
        longint v;
        v = q30 / (longint'(1) << 30);
        if (flip)
            v = -v;
        return v[15:0];
    endfunction

    function void note_tick(logic signed [15:0] tx, logic signed [15:0] ty,
                            logic signed [16:0] th, logic signed [15:0] cx,
                            logic signed [15:0] cy, logic signed [16:0] yw);
        longint dx, dy, manh, err, aerr, spd, turn, yaw_a, dir, num;
        longint x, y, z, xs, ys, tq;
        bit neg;
        t_wheels r;
        dx = longint'(tx) - longint'(cx);
        dy = longint'(ty) - longint'(cy);
        manh = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        err = longint'(th) - longint'(yw);
        aerr = err < 0 ? -err : err;
        if (manh <= longint'(dist_tol) && aerr <= longint'(angle_tol)) begin
            r = '0;
            pending.push_back(r);
            return;
        end
        spd = manh > longint'(speed_limit) ? longint'(speed_limit) : manh;
        turn = err / 10;
        if (turn > longint'(turn_limit)) turn = longint'(turn_limit);
        if (turn < -longint'(turn_limit)) turn = -longint'(turn_limit);
        // Floor division of the scaled yaw, rounding half up.
        num = longint'(yw) * (longint'(1) << 19) + 36000;
        yaw_a = num / 72000;
        if (num % 72000 != 0 && num < 0)
            yaw_a -= 1;
        dir = (heading_of(dx, dy) - yaw_a) & ((longint'(1) << 18) - 1);
        if (dir >= (longint'(1) << 17))
            dir -= longint'(1) << 18;
        x = spd * 64'sd652032874;
        y = 0;
        z = dir;
        neg = 0;
        if (z > (longint'(1) << 16)) begin
            z -= longint'(1) << 17; neg = 1;
        end else if (z < -(longint'(1) << 16)) begin
            z += longint'(1) << 17; neg = 1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_step(i);
            end else begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        tq = turn <<< 30;
        r.wa = to_wheel(x - y - tq, 1);
        r.wb = to_wheel(x + y + tq, 0);
        r.wc = to_wheel(x + y - tq, 1);
        r.wd = to_wheel(x - y + tq, 0);
        r.busy = 1'b1;
        pending.push_back(r);
    endfunction

    function void check_wheels(t_wheels got);
        t_wheels exp;
        if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (exp != got) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("mismatch: exp a=%0d b=%0d c=%0d d=%0d busy=%0d got a=%0d b=%0d c=%0d d=%0d busy=%0d",
                         exp.wa, exp.wb, exp.wc, exp.wd, exp.busy,
                         got.wa, got.wb, got.wc, got.wd, got.busy);
        end
    endfunction
endclass

module tb;
    import mgpc_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] tx = 0, ty = 0, cx = 0, cy = 0;
    logic signed [16:0] th = 0, yw = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] wa, wb, wc, wd;
    logic busy;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [7:0] cfg_idx = 0;
    logic [15:0] cfg_data = 0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    bit done = 0;

    wheel_scoreboard board = new();

    mecanum_goto_point_controller_top DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_target_x(tx), .i_target_y(ty), .i_target_heading(th),
        .i_current_x(cx), .i_current_y(cy), .i_yaw(yw),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_wheel_a(wa), .o_wheel_b(wb), .o_wheel_c(wc), .o_wheel_d(wd),
        .o_busy_res(busy),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            board.check_wheels({wa, wb, wc, wd, busy});
        if (in_valid && in_ready)
            board.note_tick(tx, ty, th, cx, cy, yw);
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !done) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The valid stays high after the handshake; the next call either offers
    // a new transaction or drops it in its idle loop.
    task automatic send_tick(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [16:0] h, logic signed [15:0] c,
                             logic signed [15:0] d, logic signed [16:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tx <= a; ty <= b; th <= h; cx <= c; cy <= d; yw <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [7:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [16:0] rand_angle();
        case ($urandom_range(3))
            0: return 17'($signed($urandom_range(72000)) - 36000);
            1: return 17'($urandom);
            default: return 17'($signed($urandom_range(800)) - 400);
        endcase
    endfunction

    task automatic random_ticks(int n);
        logic signed [15:0] x0, y0;
        for (int k = 0; k < n; k++) begin
            x0 = 16'($urandom);
            y0 = 16'($urandom);
            case ($urandom_range(3))
                0: send_tick(16'($urandom), 16'($urandom), rand_angle(),
                             16'($urandom), 16'($urandom), rand_angle());
                1: send_tick(x0 + 16'($signed($urandom_range(12)) - 6),
                             y0 + 16'($signed($urandom_range(12)) - 6),
                             rand_angle(), x0, y0, rand_angle());
                default: send_tick(x0 + 16'($signed($urandom_range(2400)) - 1200),
                                   y0 + 16'($signed($urandom_range(2400)) - 1200),
                                   rand_angle(), x0, y0, rand_angle());
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: arrival, zero offset, field extremes, wrapping angles.
        send_tick(0, 0, 0, 0, 0, 0);
        send_tick(3, 2, 150, 0, 0, -50);
        send_tick(10, 0, 0, 0, 0, 0);
        send_tick(0, 0, 5000, 0, 0, 0);
        send_tick(32767, 32767, 36000, -32768, -32768, -36000);
        send_tick(-32768, -32768, -36000, 32767, 32767, 36000);
        send_tick(100, 0, 0, 0, 0, 9000);
        send_tick(0, 100, 0, 0, 0, -9000);
        send_tick(-100, 0, 0, 0, 0, 18000);
        send_tick(0, -100, 0, 0, 0, -18000);
        send_tick(-100, -1, 17'sh0FFFF, 0, 0, -17'sh10000);
        send_tick(-100, 1, -17'sh10000, 0, 0, 17'sh0FFFF);
        send_tick(16'h5555, 16'hAAAA, 17'h15555, 16'hAAAA, 16'h5555, 17'h0AAAA);
        send_tick(7, -9, -1, 7, -9, 0);
        drain();

        write_cfg(CFG_SPEED_LIMIT, 16'hFFFF);
        write_cfg(CFG_TURN_LIMIT, 1023);
        write_cfg(CFG_DIST_TOL, 1023);
        write_cfg(CFG_ANGLE_TOL, 16'hFFFF);
        write_cfg(8'd7, 16'h1234);
        random_ticks(60);
        drain();

        write_cfg(CFG_SPEED_LIMIT, 0);
        write_cfg(CFG_TURN_LIMIT, 0);
        write_cfg(CFG_DIST_TOL, 0);
        write_cfg(CFG_ANGLE_TOL, 0);
        send_idle_pct = 64;
        random_ticks(60);
        drain();

        write_cfg(CFG_SPEED_LIMIT, 1000);
        write_cfg(CFG_TURN_LIMIT, 1000);
        write_cfg(CFG_DIST_TOL, 20);
        write_cfg(CFG_ANGLE_TOL, 36000);
        send_idle_pct = 0;
        stall_pct = 64;
        random_ticks(150);
        drain();

        write_cfg(CFG_SPEED_LIMIT, 500);
        write_cfg(CFG_TURN_LIMIT, 200);
        write_cfg(CFG_DIST_TOL, 5);
        write_cfg(CFG_ANGLE_TOL, 200);
        send_idle_pct = 31;
        stall_pct = 31;
        random_ticks(150);

        // Long receiver hold-off so the pipeline fills and backs up the input.
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            random_ticks(150);
        join
        drain();
        done = 1;

        if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
design/mgpc_pkg.sv
design/mgpc_vec_cordic.sv
design/mgpc_rot_cordic.sv
design/mecanum_goto_point_controller_top.sv
bench/tb.sv
